[rtl/bsa_pkg.sv]
// ============================================================================
// bsa_pkg
// Shared types and constants for the bitmap slot allocator with body lookup.
// ============================================================================
package bsa_pkg;

    localparam int SLOTS     = 2048;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int KIND_BITS = 3;
    localparam int BODY_BITS = 16;
    localparam int OP_BITS   = 3;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(SLOTS - 1);
    localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_QUERY = 3'd2,
        OP_FIND  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SCAN,
        ST_QUERY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 active;
        logic [KIND_BITS-1:0] kind;
        logic [BODY_BITS-1:0] body;
    } entry_t;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        entry_t               wdata;
        logic                 re;
        logic [SLOT_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic                 ok;
        logic                 active;
        logic [KIND_BITS-1:0] kind;
        logic [BODY_BITS-1:0] body;
    } result_t;

endpackage

[rtl/bitmap_slot_allocator_with_lookup_core.sv]
// ============================================================================
// bitmap_slot_allocator_with_lookup_core
// Top level: stream ports, output register, sequencer and entry memory.
// ============================================================================
// Each transaction carries one operation and returns exactly one result. The
// block handles one operation at a time; a single scan unit steps through the
// entry memory one slot per cycle. Allocate and find end early at the first
// free slot or first matching body id. After reset a clearing pass writes
// every entry to zero before the first transaction is accepted. A finished
// result sits in an output register, so the next transaction can be accepted
// while it waits.
module bitmap_slot_allocator_with_lookup_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [10:0] slot_id, [13:11] kind_in, [29:14] body_in, [31:30] zero
    input  logic [31:0] s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] result_slot, [11] ok, [12] active_out, [15:13] kind_out,
    // [31:16] body_out
    output logic [31:0] m_axis_tdata
);

    bsa_pkg::mem_req_t mem_req;
    bsa_pkg::entry_t   rd_data;
    bsa_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;

    assign res_ready = !m_valid_reg || m_axis_tready;

    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .op        (s_axis_tuser),
        .slot_id   (s_axis_tdata[10:0]),
        .kind_in   (s_axis_tdata[13:11]),
        .body_in   (s_axis_tdata[29:14]),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    bsa_table u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= {res.body, res.kind, res.active, res.ok, res.slot};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[rtl/bsa_table.sv]
// ============================================================================
// bsa_table
// Slot entry memory: active bit, kind and body id, one write and one
// registered read per cycle.
// ============================================================================
module bsa_table (
    input  logic              clk,
    input  bsa_pkg::mem_req_t req,
    output bsa_pkg::entry_t   rd_data
);

    bsa_pkg::entry_t mem [bsa_pkg::SLOTS];
    bsa_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bsa_ctrl.sv]
// ============================================================================
// bsa_ctrl
// Sequencer that drives the slot scan unit: one slot address per cycle for
// allocate, find and clear, plus single accesses for free and query.
// ============================================================================
module bsa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bsa_pkg::OP_BITS-1:0]     op,
    input  logic [bsa_pkg::SLOT_BITS-1:0]   slot_id,
    input  logic [bsa_pkg::KIND_BITS-1:0]   kind_in,
    input  logic [bsa_pkg::BODY_BITS-1:0]   body_in,
    output bsa_pkg::mem_req_t               mem_req,
    input  bsa_pkg::entry_t                 rd_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output bsa_pkg::result_t                res
);

    bsa_pkg::state_t                 state_reg, state_next;
    logic [bsa_pkg::SLOT_BITS-1:0]   issue_reg, issue_next;
    logic                            issue_done_reg, issue_done_next;
    logic                            chk_vld_reg, chk_vld_next;
    logic [bsa_pkg::SLOT_BITS-1:0]   chk_slot_reg, chk_slot_next;
    logic                            wipe_res_reg, wipe_res_next;
    bsa_pkg::op_t                    op_reg, op_next;
    logic [bsa_pkg::KIND_BITS-1:0]   kind_reg, kind_next;
    logic [bsa_pkg::BODY_BITS-1:0]   body_reg, body_next;
    bsa_pkg::result_t                res_reg, res_next;
    logic                            hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bsa_pkg::ST_WIPE;
            issue_reg      <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            wipe_res_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            wipe_res_reg   <= wipe_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_slot_reg <= chk_slot_next;
        op_reg       <= op_next;
        kind_reg     <= kind_next;
        body_reg     <= body_next;
        res_reg      <= res_next;
    end

    // A checked slot hits on a free entry for allocate, on a body match for find.
    assign hit = chk_vld_reg && ((op_reg == bsa_pkg::OP_ALLOC) ? !rd_data.active
                                                               : (rd_data.body == body_reg));

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_slot_next   = chk_slot_reg;
        wipe_res_next   = wipe_res_reg;
        op_next         = op_reg;
        kind_next       = kind_reg;
        body_next       = body_reg;
        res_next        = res_reg;
        mem_req         = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            bsa_pkg::ST_WIPE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = issue_reg;
                issue_next    = issue_reg + 1'b1;
                if (issue_reg == bsa_pkg::LAST_SLOT)
                begin
                    res_next   = '0;
                    state_next = wipe_res_reg ? bsa_pkg::ST_DONE : bsa_pkg::ST_IDLE;
                end
            end

            bsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = bsa_pkg::op_t'(op);
                    kind_next       = kind_in;
                    body_next       = body_in;
                    res_next        = '0;
                    issue_next      = bsa_pkg::FIRST_SLOT;
                    issue_done_next = 1'b0;
                    unique case (bsa_pkg::op_t'(op))
                        bsa_pkg::OP_ALLOC:
                        begin
                            state_next = bsa_pkg::ST_SCAN;
                        end
                        bsa_pkg::OP_FIND:
                        begin
                            // Body id zero never matches anything.
                            state_next = (body_in == '0) ? bsa_pkg::ST_DONE
                                                         : bsa_pkg::ST_SCAN;
                        end
                        bsa_pkg::OP_FREE:
                        begin
                            mem_req.we    = (slot_id != '0);
                            mem_req.waddr = slot_id;
                            state_next    = bsa_pkg::ST_DONE;
                        end
                        bsa_pkg::OP_QUERY:
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = slot_id;
                            state_next    = bsa_pkg::ST_QUERY;
                        end
                        bsa_pkg::OP_CLEAR:
                        begin
                            wipe_res_next = 1'b1;
                            state_next    = bsa_pkg::ST_WIPE;
                        end
                        default:
                        begin
                            state_next = bsa_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            bsa_pkg::ST_QUERY:
            begin
                res_next.active = rd_data.active;
                res_next.kind   = rd_data.kind;
                res_next.body   = rd_data.body;
                state_next      = bsa_pkg::ST_DONE;
            end

            bsa_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.slot = chk_slot_reg;
                    res_next.ok   = 1'b1;
                    if (op_reg == bsa_pkg::OP_ALLOC)
                    begin
                        mem_req.we           = 1'b1;
                        mem_req.waddr        = chk_slot_reg;
                        mem_req.wdata.active = 1'b1;
                        mem_req.wdata.kind   = kind_reg;
                        mem_req.wdata.body   = body_reg;
                    end
                    state_next = bsa_pkg::ST_DONE;
                end
                else if (issue_done_reg && !chk_vld_reg)
                begin
                    state_next = bsa_pkg::ST_DONE;
                end
                else if (!issue_done_reg)
                begin
                    mem_req.re      = 1'b1;
                    mem_req.raddr   = issue_reg;
                    chk_vld_next    = 1'b1;
                    chk_slot_next   = issue_reg;
                    issue_next      = issue_reg + 1'b1;
                    issue_done_next = (issue_reg == bsa_pkg::LAST_SLOT);
                end
            end

            bsa_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    wipe_res_next = 1'b0;
                    state_next    = bsa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// Slot allocator testbench
// Drives allocate, free, query, find-by-body and clear-all transactions into
// the allocator and checks every result against a behavioral table model:
// a short table of directed cases, then random traffic with random stalls on
// both streams and a stretch with no stalls at all.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_ITEMS   = 260;

    typedef logic [bsa_pkg::OP_BITS-1:0]   op_code_t;
    typedef logic [bsa_pkg::SLOT_BITS-1:0] slot_id_t;
    typedef logic [bsa_pkg::KIND_BITS-1:0] kind_code_t;
    typedef logic [bsa_pkg::BODY_BITS-1:0] body_id_t;

    // Operation codes that the block must treat as no-ops.
    localparam op_code_t OP_RSVD5 = 3'd5;
    localparam op_code_t OP_RSVD6 = 3'd6;
    localparam op_code_t OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [bsa_pkg::SLOT_BITS-1:0] slot;
        logic                          ok;
        logic                          active;
        logic [bsa_pkg::KIND_BITS-1:0] kind;
        logic [bsa_pkg::BODY_BITS-1:0] body;
    } slot_result_t;

    typedef struct packed {
        logic [bsa_pkg::OP_BITS-1:0]   op;
        logic [bsa_pkg::SLOT_BITS-1:0] sid;
        logic [bsa_pkg::KIND_BITS-1:0] kind;
        logic [bsa_pkg::BODY_BITS-1:0] body;
        logic                          typed;
        slot_result_t                  res;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Model of the slot table.
    logic                          slot_busy [bsa_pkg::SLOTS];
    logic [bsa_pkg::KIND_BITS-1:0] slot_kind [bsa_pkg::SLOTS];
    logic [bsa_pkg::BODY_BITS-1:0] slot_body [bsa_pkg::SLOTS];

    slot_result_t pending_results[$];
    op_row_t      op_rows[$];
    int           errors = 0;
    int           stall_cycles = 0;
    bit           idle_on = 1'b1;

    bitmap_slot_allocator_with_lookup_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Applies one operation to the table model and returns its result.
    function automatic slot_result_t apply_slot_op(
        input logic [bsa_pkg::OP_BITS-1:0]   op,
        input logic [bsa_pkg::SLOT_BITS-1:0] sid,
        input logic [bsa_pkg::KIND_BITS-1:0] kind,
        input logic [bsa_pkg::BODY_BITS-1:0] body
    );
        slot_result_t r;
        int s;
        r = '0;
        case (op)
            bsa_pkg::OP_ALLOC:
            begin
                for (s = 1; s < bsa_pkg::SLOTS && !r.ok; s++)
                begin
                    if (!slot_busy[s])
                    begin
                        slot_busy[s] = 1'b1;
                        slot_kind[s] = kind;
                        slot_body[s] = body;
                        r.slot = slot_id_t'(s);
                        r.ok = 1'b1;
                    end
                end
            end
            bsa_pkg::OP_FREE:
            begin
                if (sid != 0)
                begin
                    slot_busy[sid] = 1'b0;
                    slot_kind[sid] = '0;
                    slot_body[sid] = '0;
                end
            end
            bsa_pkg::OP_QUERY:
            begin
                r.active = slot_busy[sid];
                r.kind = slot_kind[sid];
                r.body = slot_body[sid];
            end
            bsa_pkg::OP_FIND:
            begin
                if (body != 0)
                begin
                    for (s = 1; s < bsa_pkg::SLOTS && !r.ok; s++)
                    begin
                        if (slot_body[s] == body)
                        begin
                            r.slot = slot_id_t'(s);
                            r.ok = 1'b1;
                        end
                    end
                end
            end
            bsa_pkg::OP_CLEAR:
            begin
                for (s = 1; s < bsa_pkg::SLOTS; s++)
                begin
                    slot_busy[s] = 1'b0;
                    slot_kind[s] = '0;
                    slot_body[s] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Returns an active slot near a random start, or a random slot if none is active.
    function automatic logic [bsa_pkg::SLOT_BITS-1:0] pick_busy_slot();
        int start;
        int s;
        int i;
        start = $urandom_range(1, bsa_pkg::SLOTS - 1);
        for (i = 0; i < bsa_pkg::SLOTS - 1; i++)
        begin
            s = 1 + (start - 1 + i) % (bsa_pkg::SLOTS - 1);
            if (slot_busy[s])
                return slot_id_t'(s);
        end
        return slot_id_t'(start);
    endfunction

    task automatic post_op(
        input logic [bsa_pkg::OP_BITS-1:0]   op,
        input logic [bsa_pkg::SLOT_BITS-1:0] sid,
        input logic [bsa_pkg::KIND_BITS-1:0] kind,
        input logic [bsa_pkg::BODY_BITS-1:0] body,
        input slot_result_t                  res
    );
        pending_results.push_back(res);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 50);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, body, kind, sid};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic post_predicted(
        input logic [bsa_pkg::OP_BITS-1:0]   op,
        input logic [bsa_pkg::SLOT_BITS-1:0] sid,
        input logic [bsa_pkg::KIND_BITS-1:0] kind,
        input logic [bsa_pkg::BODY_BITS-1:0] body
    );
        post_op(op, sid, kind, body, apply_slot_op(op, sid, kind, body));
    endtask

    task automatic add_row(
        input logic [bsa_pkg::OP_BITS-1:0]   op,
        input logic [bsa_pkg::SLOT_BITS-1:0] sid,
        input logic [bsa_pkg::KIND_BITS-1:0] kind,
        input logic [bsa_pkg::BODY_BITS-1:0] body,
        input logic                          typed,
        input logic [bsa_pkg::SLOT_BITS-1:0] exp_slot,
        input logic                          exp_ok
    );
        op_row_t row;
        row = '0;
        row.op = op;
        row.sid = sid;
        row.kind = kind;
        row.body = body;
        row.typed = typed;
        row.res.slot = exp_slot;
        row.res.ok = exp_ok;
        op_rows.push_back(row);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic aimed at live slots and stored body ids.
    task automatic random_op();
        logic [bsa_pkg::OP_BITS-1:0]   op;
        logic [bsa_pkg::SLOT_BITS-1:0] sid;
        logic [bsa_pkg::KIND_BITS-1:0] kind;
        logic [bsa_pkg::BODY_BITS-1:0] body;
        int pick;
        pick = $urandom_range(0, 99);
        sid = slot_id_t'($urandom_range(0, bsa_pkg::SLOTS - 1));
        kind = kind_code_t'($urandom_range(0, 7));
        body = body_id_t'($urandom_range(0, 65535));
        if (pick < 36)
        begin
            op = bsa_pkg::OP_ALLOC;
            if ($urandom_range(0, 99) < 15)
                body = slot_body[pick_busy_slot()];
            else if ($urandom_range(0, 99) < 5)
                body = '0;
        end
        else if (pick < 56)
        begin
            op = bsa_pkg::OP_FREE;
            if ($urandom_range(0, 99) < 80)
                sid = pick_busy_slot();
        end
        else if (pick < 76)
        begin
            op = bsa_pkg::OP_QUERY;
            if ($urandom_range(0, 99) < 80)
                sid = pick_busy_slot();
        end
        else if (pick < 91)
        begin
            op = bsa_pkg::OP_FIND;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                body = slot_body[pick_busy_slot()];
            else if (pick < 80)
                body = '0;
        end
        else if (pick < 96)
            op = bsa_pkg::OP_CLEAR;
        else
            op = op_code_t'($urandom_range(OP_RSVD5, OP_RSVD7));
        post_predicted(op, sid, kind, body);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    // Result stream: random back-pressure, changed at the falling edge.
    always @(negedge clk)
        m_axis_tready <= rst_n && !(idle_on && $urandom_range(0, 99) < 7);

    always @(posedge clk)
    begin
        slot_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %0h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                compare_field("result_slot", 32'(exp_res.slot), 32'(m_axis_tdata[10:0]));
                compare_field("ok", 32'(exp_res.ok), 32'(m_axis_tdata[11]));
                compare_field("active_out", 32'(exp_res.active), 32'(m_axis_tdata[12]));
                compare_field("kind_out", 32'(exp_res.kind), 32'(m_axis_tdata[15:13]));
                compare_field("body_out", 32'(exp_res.body), 32'(m_axis_tdata[31:16]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        op_row_t      row;
        slot_result_t res;
        logic [bsa_pkg::SLOT_BITS-1:0] sid;
        int i;

        for (i = 0; i < bsa_pkg::SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_kind[i] = '0;
            slot_body[i] = '0;
        end

        // Directed cases; typed expectations only where they are obvious.
        add_row(bsa_pkg::OP_QUERY, 11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd2047, 3'd7, 16'hffff, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'hffff, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_ALLOC, 11'd0,    3'd7, 16'hffff, 1'b1, 11'd1, 1'b1);
        add_row(bsa_pkg::OP_ALLOC, 11'd2047, 3'd0, 16'h0000, 1'b1, 11'd2, 1'b1);
        add_row(bsa_pkg::OP_ALLOC, 11'd5,    3'd5, 16'h1234, 1'b1, 11'd3, 1'b1);
        add_row(bsa_pkg::OP_ALLOC, 11'd0,    3'd2, 16'hffff, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd1,    3'd0, 16'h0000, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd2,    3'd0, 16'h0000, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'hffff, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FREE,  11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FREE,  11'd1,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'hffff, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd1,    3'd0, 16'h0000, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_ALLOC, 11'd0,    3'd3, 16'habcd, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FREE,  11'd2047, 3'd7, 16'hffff, 1'b1, 11'd0, 1'b0);
        add_row(OP_RSVD5,          11'd2047, 3'd7, 16'hffff, 1'b1, 11'd0, 1'b0);
        add_row(OP_RSVD6,          11'd1,    3'd1, 16'h0001, 1'b1, 11'd0, 1'b0);
        add_row(OP_RSVD7,          11'd2047, 3'd7, 16'hffff, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_CLEAR, 11'd0,    3'd0, 16'h0000, 1'b1, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_QUERY, 11'd3,    3'd0, 16'h0000, 1'b0, 11'd0, 1'b0);
        add_row(bsa_pkg::OP_FIND,  11'd0,    3'd0, 16'h1234, 1'b0, 11'd0, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (op_rows[i])
        begin
            row = op_rows[i];
            res = apply_slot_op(row.op, row.sid, row.kind, row.body);
            if (row.typed)
                res = row.res;
            post_op(row.op, row.sid, row.kind, row.body, res);
        end

        // Hold the sender back until the block has answered everything.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (i = 0; i < RANDOM_ITEMS / 3; i++)
            random_op();

        // A long unstalled stretch on both sides, then top-slot and random-slot probes.
        idle_on = 1'b0;
        for (i = 0; i < RANDOM_ITEMS / 3; i++)
            random_op();
        post_predicted(bsa_pkg::OP_QUERY, bsa_pkg::LAST_SLOT, '0, '0);
        post_predicted(bsa_pkg::OP_FIND, '0, '0, slot_body[bsa_pkg::LAST_SLOT]);
        sid = slot_id_t'($urandom_range(2, bsa_pkg::SLOTS - 2));
        post_predicted(bsa_pkg::OP_FREE, sid, '0, '0);
        post_predicted(bsa_pkg::OP_ALLOC, '0, 3'd4, 16'h0042);
        post_predicted(bsa_pkg::OP_QUERY, sid, '0, '0);
        idle_on = 1'b1;

        for (i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
            random_op();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/bsa_pkg.sv
rtl/bsa_table.sv
rtl/bsa_ctrl.sv
rtl/bitmap_slot_allocator_with_lookup_core.sv
test/tb_top.sv
